FILE: rtl/e2q_pkg.sv
// Package: constants, CORDIC arctangent table and shared types for the Euler to quaternion block.
package e2q_pkg;

  localparam int unsigned AngleW  = 16;
  localparam int unsigned QuatW   = 16;
  localparam int unsigned CordW   = 34;
  localparam int unsigned Iters   = 18;
  localparam int unsigned TrigW   = 17;

  localparam logic signed [CordW-1:0] HalfPiQ28 = 34'sd421657428;
  localparam logic signed [CordW-1:0] PiQ28     = 34'sd843314857;
  localparam logic signed [CordW-1:0] GainQ30   = 34'sd652032874;
  localparam logic signed [QuatW-1:0] Q14One    = 16'sd16384;

  typedef struct packed {
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
    logic signed [CordW-1:0] z;
    logic                    neg;
  } cord_t;

  typedef struct packed {
    logic signed [TrigW-1:0] s;
    logic signed [TrigW-1:0] c;
  } trig_t;

  function automatic logic signed [CordW-1:0] atan_at(input logic [4:0] i);
    logic signed [CordW-1:0] r;
    case (i)
      5'd0:  r = 34'sd210828714;
      5'd1:  r = 34'sd124459457;
      5'd2:  r = 34'sd65760959;
      5'd3:  r = 34'sd33381290;
      5'd4:  r = 34'sd16755422;
      5'd5:  r = 34'sd8385879;
      5'd6:  r = 34'sd4193963;
      5'd7:  r = 34'sd2097109;
      5'd8:  r = 34'sd1048571;
      5'd9:  r = 34'sd524287;
      5'd10: r = 34'sd262144;
      5'd11: r = 34'sd131072;
      5'd12: r = 34'sd65536;
      5'd13: r = 34'sd32768;
      5'd14: r = 34'sd16384;
      5'd15: r = 34'sd8192;
      5'd16: r = 34'sd4096;
      5'd17: r = 34'sd2048;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/e2q_cordic.sv
// Pipelined CORDIC: half-angle sine and cosine in Q.15, one rotation per stage.
module e2q_cordic (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [e2q_pkg::AngleW-1:0]   angle_i,
  output e2q_pkg::trig_t                      trig_o
);
  import e2q_pkg::*;

  cord_t stage_q [Iters+1];
  cord_t fold_d;
  logic signed [CordW-1:0] z0;
  logic signed [CordW:0] xr, yr;
  trig_t trig_q;

  always_comb begin
    z0 = CordW'(angle_i) <<< 14;
    fold_d.x = GainQ30;
    fold_d.y = '0;
    fold_d.z = z0;
    fold_d.neg = 1'b0;
    if (z0 > HalfPiQ28) begin
      fold_d.z = z0 - PiQ28;
      fold_d.neg = 1'b1;
    end else if (z0 < -HalfPiQ28) begin
      fold_d.z = z0 + PiQ28;
      fold_d.neg = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) stage_q[0] <= fold_d;
  end

  for (genvar g = 0; g < Iters; g++) begin : g_rot
    cord_t nx_d;
    always_comb begin
      nx_d = stage_q[g];
      if (!stage_q[g].z[CordW-1]) begin
        nx_d.x = stage_q[g].x - (stage_q[g].y >>> g);
        nx_d.y = stage_q[g].y + (stage_q[g].x >>> g);
        nx_d.z = stage_q[g].z - atan_at(5'(g));
      end else begin
        nx_d.x = stage_q[g].x + (stage_q[g].y >>> g);
        nx_d.y = stage_q[g].y - (stage_q[g].x >>> g);
        nx_d.z = stage_q[g].z + atan_at(5'(g));
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) stage_q[g+1] <= nx_d;
    end
  end

  always_comb begin
    xr = (stage_q[Iters].neg ? -{stage_q[Iters].x[CordW-1], stage_q[Iters].x}
                             :  {stage_q[Iters].x[CordW-1], stage_q[Iters].x})
         + (CordW+1)'(16384);
    yr = (stage_q[Iters].neg ? -{stage_q[Iters].y[CordW-1], stage_q[Iters].y}
                             :  {stage_q[Iters].y[CordW-1], stage_q[Iters].y})
         + (CordW+1)'(16384);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      trig_q.c <= TrigW'(xr >>> 15);
      trig_q.s <= TrigW'(yr >>> 15);
    end
  end

  assign trig_o = trig_q;

endmodule

FILE: rtl/e2q_combine.sv
// Product stages: triple products, sums, rounding and saturation of x, y, z, w.
module e2q_combine (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  e2q_pkg::trig_t                    roll_i,
  input  e2q_pkg::trig_t                    pitch_i,
  input  e2q_pkg::trig_t                    yaw_i,
  output logic signed [e2q_pkg::QuatW-1:0]  quat_x_o,
  output logic signed [e2q_pkg::QuatW-1:0]  quat_y_o,
  output logic signed [e2q_pkg::QuatW-1:0]  quat_z_o,
  output logic signed [e2q_pkg::QuatW-1:0]  quat_w_o
);
  import e2q_pkg::*;

  localparam int unsigned PW = 2*TrigW;
  localparam int unsigned SW = 3*TrigW + 1;

  // stage A: roll x pitch pairs
  logic signed [PW-1:0] cc_q, cs_q, sc_q, ss_q;
  trig_t yaw_q;
  // stage B: eight triple products
  logic signed [SW-2:0] p_q [8];
  // stage C: sums
  logic signed [SW-1:0] s_q [4];
  logic signed [QuatW-1:0] q_q [4];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cc_q  <= roll_i.c * pitch_i.c;
      cs_q  <= roll_i.c * pitch_i.s;
      sc_q  <= roll_i.s * pitch_i.c;
      ss_q  <= roll_i.s * pitch_i.s;
      yaw_q <= yaw_i;
      p_q[0] <= sc_q * yaw_q.c;  // sr cp cy
      p_q[1] <= cs_q * yaw_q.s;  // cr sp sy
      p_q[2] <= cs_q * yaw_q.c;  // cr sp cy
      p_q[3] <= sc_q * yaw_q.s;  // sr cp sy
      p_q[4] <= cc_q * yaw_q.s;  // cr cp sy
      p_q[5] <= ss_q * yaw_q.c;  // sr sp cy
      p_q[6] <= cc_q * yaw_q.c;  // cr cp cy
      p_q[7] <= ss_q * yaw_q.s;  // sr sp sy
      s_q[0] <= SW'(p_q[0]) - SW'(p_q[1]);
      s_q[1] <= SW'(p_q[2]) + SW'(p_q[3]);
      s_q[2] <= SW'(p_q[4]) - SW'(p_q[5]);
      s_q[3] <= SW'(p_q[6]) + SW'(p_q[7]);
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_fin
    logic signed [SW-1:0] r;
    logic signed [SW-32:0] t;
    logic signed [QuatW-1:0] q_d;
    always_comb begin
      r = s_q[g] + SW'(64'sd1073741824);
      t = r[SW-1:31];
      if (t > (SW-31)'(Q14One)) q_d = Q14One;
      else if (t < -(SW-31)'(Q14One)) q_d = -Q14One;
      else q_d = QuatW'(t);
    end
    always_ff @(posedge clk_i) begin
      if (en_i) q_q[g] <= q_d;
    end
  end

  assign quat_x_o = q_q[0];
  assign quat_y_o = q_q[1];
  assign quat_z_o = q_q[2];
  assign quat_w_o = q_q[3];

endmodule

FILE: rtl/euler_to_quaternion_top.sv
// Pipeline: input beat to output beat through fold, 18 CORDIC, round and 4 product/sum/sat stages.
// Throughput: one beat per cycle; the whole pipeline advances whenever the
// output register is empty or being taken, so a stall freezes every stage.
// Reset: asynchronous, active low; clears only the valid bits, data is not reset.
// Top level: Euler ZYX angle triple to Q1.14 quaternion, stream ports.
module euler_to_quaternion_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // roll_angle, pitch_angle, yaw_angle
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata    // quat_x, quat_y, quat_z, quat_w
);
  import e2q_pkg::*;

  localparam int unsigned Lat = Iters + 2 + 4;

  logic [Lat-1:0] vld_q;
  logic en;
  trig_t tr, tp, ty;
  logic signed [QuatW-1:0] qx, qy, qz, qw;

  assign en = !vld_q[Lat-1] || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], s_axis_tvalid};
    end
  end

  e2q_cordic u_roll  (.clk_i, .en_i(en), .angle_i(s_axis_tdata[15:0]),  .trig_o(tr));
  e2q_cordic u_pitch (.clk_i, .en_i(en), .angle_i(s_axis_tdata[31:16]), .trig_o(tp));
  e2q_cordic u_yaw   (.clk_i, .en_i(en), .angle_i(s_axis_tdata[47:32]), .trig_o(ty));

  e2q_combine u_comb (
    .clk_i, .en_i(en), .roll_i(tr), .pitch_i(tp), .yaw_i(ty),
    .quat_x_o(qx), .quat_y_o(qy), .quat_z_o(qz), .quat_w_o(qw)
  );

  assign m_axis_tvalid = vld_q[Lat-1];
  assign m_axis_tdata  = {qw, qz, qy, qx};

endmodule

FILE: rtl/e2q_checker.sv
// Port-level checker for the Euler to quaternion top level, bound to it.
module e2q_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed under stall");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output space");
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $signed(m_axis_tdata[15:0]) <= 16384 &&
                      $signed(m_axis_tdata[15:0]) >= -16384 &&
                      $signed(m_axis_tdata[63:48]) <= 16384 &&
                      $signed(m_axis_tdata[63:48]) >= -16384)
    else $error("component out of range");
endmodule

bind euler_to_quaternion_top e2q_checker u_chk (.*);

FILE: dv/euler_to_quaternion_top_tb.sv
// Testbench: drives Euler angle triples into the quaternion block and checks each beat against a predictor.
module euler_to_quaternion_top_tb;
  import e2q_pkg::*;

  typedef struct {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    bit                 known;
    logic [63:0]        quat;
  } angle_row_t;

  localparam int unsigned StallLimit = 5000;
  localparam int unsigned NumRandom  = 1130;
  localparam int unsigned Latency    = 24;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;

  logic [63:0] quat_q[$];
  int          n_errors;
  int          n_sent;
  int          n_checked;
  int          idle_cycles;
  int          send_pct;
  int          stall_pct;
  bit          hold_off;

  euler_to_quaternion_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // roll_angle, pitch_angle, yaw_angle
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)    // quat_x, quat_y, quat_z, quat_w
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic void half_sin_cos(logic signed [15:0] code, output longint s15,
                                       output longint c15);
    longint z, x, y, dx, dy;
    bit     flip;
    z = longint'(code) * 16384;
    x = GainQ30;
    y = 0;
    flip = 1'b0;
    if (z > HalfPiQ28) begin
      z -= PiQ28;
      flip = 1'b1;
    end else if (z < -longint'(HalfPiQ28)) begin
      z += PiQ28;
      flip = 1'b1;
    end
    for (int i = 0; i < Iters; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_q28(i);
      end else begin
        x += dx; y -= dy; z += arctan_q28(i);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c15 = floor_shift(x + 16384, 15);
    s15 = floor_shift(y + 16384, 15);
  endfunction

  function automatic longint arctan_q28(int i);
    longint t[18] = '{210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
                      4193963, 2097109, 1048571, 524287, 262144, 131072,
                      65536, 32768, 16384, 8192, 4096, 2048};
    return t[i];
  endfunction

  function automatic logic [15:0] round_sat_q14(longint s45);
    longint q;
    q = floor_shift(s45 + (longint'(1) << 30), 31);
    if (q > 16384) q = 16384;
    if (q < -16384) q = -16384;
    return q[15:0];
  endfunction

  function automatic logic [63:0] euler_to_quat(logic signed [15:0] roll,
                                               logic signed [15:0] pitch,
                                               logic signed [15:0] yaw);
    longint sr, cr, sp, cp, sy, cy;
    logic [15:0] qx, qy, qz, qw;
    half_sin_cos(roll, sr, cr);
    half_sin_cos(pitch, sp, cp);
    half_sin_cos(yaw, sy, cy);
    qx = round_sat_q14(sr * cp * cy - cr * sp * sy);
    qy = round_sat_q14(cr * sp * cy + sr * cp * sy);
    qz = round_sat_q14(cr * cp * sy - sr * sp * cy);
    qw = round_sat_q14(cr * cp * cy + sr * sp * sy);
    return {qw, qz, qy, qx};
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s at beat %0d: got %0d expected %0d", what, n_checked,
             $signed(got), $signed(want));
    n_errors++;
  endtask

  task automatic send_angles(logic signed [15:0] roll, logic signed [15:0] pitch,
                             logic signed [15:0] yaw);
    while (send_pct > 0 && $urandom_range(99) < send_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {yaw, pitch, roll};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    quat_q.push_back(euler_to_quat(roll, pitch, yaw));
    n_sent++;
    @(negedge clk_i);
  endtask

  // receiver side
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready <= !hold_off && !(stall_pct > 0 && $urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    logic [63:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (quat_q.size() == 0) begin
        $display("unexpected output beat %h", m_axis_tdata);
        n_errors++;
      end else begin
        want = quat_q.pop_front();
        if (m_axis_tdata[15:0] !== want[15:0])
          report_mismatch("quat_x", m_axis_tdata[15:0], want[15:0]);
        if (m_axis_tdata[31:16] !== want[31:16])
          report_mismatch("quat_y", m_axis_tdata[31:16], want[31:16]);
        if (m_axis_tdata[47:32] !== want[47:32])
          report_mismatch("quat_z", m_axis_tdata[47:32], want[47:32]);
        if (m_axis_tdata[63:48] !== want[63:48])
          report_mismatch("quat_w", m_axis_tdata[63:48], want[63:48]);
      end
      n_checked++;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    angle_row_t dir_rows[$];
    logic [63:0] want;
    int phase;
    n_errors = 0; n_sent = 0; n_checked = 0; idle_cycles = 0;
    send_pct = 0; stall_pct = 0; hold_off = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // zero angle gives the identity quaternion
    dir_rows.push_back('{16'sd0, 16'sd0, 16'sd0, 1'b1, {16'sd16384, 48'd0}});
    dir_rows.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0, '0});
    dir_rows.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 1'b0, '0});
    dir_rows.push_back('{16'sh7fff, 16'sh8000, 16'sd0, 1'b0, '0});
    dir_rows.push_back('{16'sh8000, 16'sd0, 16'sh7fff, 1'b0, '0});
    dir_rows.push_back('{16'sd0, 16'sh7fff, 16'sh8000, 1'b0, '0});
    // quadrant fold boundaries, half pi near 12868 per Q3.13 code
    dir_rows.push_back('{16'sd25735, 16'sd25736, 16'sd25737, 1'b0, '0});
    dir_rows.push_back('{-16'sd25735, -16'sd25736, -16'sd25737, 1'b0, '0});
    dir_rows.push_back('{16'sd12868, -16'sd12868, 16'sd12868, 1'b0, '0});
    dir_rows.push_back('{16'sd25736, 16'sd0, 16'sd0, 1'b0, '0});
    dir_rows.push_back('{16'sd0, 16'sd25736, 16'sd0, 1'b0, '0});
    dir_rows.push_back('{16'sd0, 16'sd0, 16'sd25736, 1'b0, '0});
    dir_rows.push_back('{16'sd1, -16'sd1, 16'sd1, 1'b0, '0});
    dir_rows.push_back('{16'sh5555, 16'shaaaa, 16'sh5555, 1'b0, '0});
    dir_rows.push_back('{16'shaaaa, 16'sh5555, 16'shaaaa, 1'b0, '0});
    dir_rows.push_back('{16'sd8192, 16'sd8192, 16'sd8192, 1'b0, '0});
    foreach (dir_rows[i]) begin
      if (dir_rows[i].known) begin
        want = euler_to_quat(dir_rows[i].roll, dir_rows[i].pitch, dir_rows[i].yaw);
        if (want !== dir_rows[i].quat)
          report_mismatch("table", want[63:48], dir_rows[i].quat[63:48]);
      end
      send_angles(dir_rows[i].roll, dir_rows[i].pitch, dir_rows[i].yaw);
    end

    // long receiver hold-off while the sender keeps offering beats
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk_i);
        hold_off = 1'b0;
      end
      repeat (60) send_angles(16'($urandom), 16'($urandom), 16'($urandom));
    join

    for (int i = 0; i < NumRandom; i++) begin
      phase = (i * 5) / NumRandom;
      case (phase)
        0: begin send_pct = 0;  stall_pct = 0;  end
        1: begin send_pct = 62; stall_pct = 0;  end
        2: begin send_pct = 0;  stall_pct = 62; end
        3: begin send_pct = 35; stall_pct = 35; end
        default: begin send_pct = $urandom_range(1) ? 0 : 20; stall_pct = 0; end
      endcase
      if ($urandom_range(3) == 0)
        send_angles($urandom_range(1) ? 16'sh7fff : 16'sh8000, 16'($urandom),
                    16'($urandom));
      else
        send_angles(16'($urandom), 16'($urandom), 16'($urandom));
    end
    s_axis_tvalid <= 1'b0;
    stall_pct = 0;

    while (quat_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 5) @(posedge clk_i);
    $display("Sent %0d angle triples, checked %0d quaternions", n_sent, n_checked);
    $display("Covered range extremes, fold edges, a long output stall and four idle mixes");
    if (n_errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
